// ----- design/pbr_pkg.sv -----
// ----------------------------------------------------------------------------
// Page buffer replacement package
// Shared widths, request, status, policy and config register codes,
// controller states, and the controller-datapath command and status bundles.
// ----------------------------------------------------------------------------
package pbr_pkg;

  localparam int NumFrames = 16;
  localparam int FidxW     = $clog2(NumFrames);
  localparam int CntW      = FidxW + 1;
  localparam int PinW      = 8;
  localparam int StepW     = CntW + 1;
  localparam int IdW       = 32;
  localparam int TsW       = 32;
  localparam int CfgDataW  = 5;
  localparam int CfgIdxW   = 2;

  typedef enum logic [2:0] {
    REQ_GET   = 3'd0,
    REQ_ROOM  = 3'd1,
    REQ_UNPIN = 3'd2,
    REQ_DIRTY = 3'd3,
    REQ_FLUSH = 3'd4,
    REQ_FREE  = 3'd5,
    REQ_CLEAR = 3'd6,
    REQ_NONE  = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_STALE    = 3'd1,
    ST_PINNED   = 3'd2,
    ST_ALL_PIN  = 3'd3,
    ST_ABSENT   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    POL_LRU   = 2'd0,
    POL_FIFO  = 2'd1,
    POL_CLOCK = 2'd2,
    POL_BAD   = 2'd3
  } policy_e;

  typedef enum logic [0:0] {
    CFG_POLICY   = 1'b0,
    CFG_CAPACITY = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_EVICT,
    S_INSTALL,
    S_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan_init;
    logic scan_step;
    logic evict;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic victim_ok;
    logic is_get;
  } stat_t;

endpackage

// ----- design/pbr_ctrl.sv -----
// ----------------------------------------------------------------------------
// Page buffer replacement controller
// Sequences lookup, victim scan, eviction, install and the result cycle.
// ----------------------------------------------------------------------------
module pbr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  pbr_pkg::stat_t stat_i,
  output pbr_pkg::cmd_t  cmd_o,
  output logic           busy_o,
  output logic           done_o
);

  pbr_pkg::state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pbr_pkg::S_IDLE: begin
        if (start_i) state_d = pbr_pkg::S_LOOK;
      end
      pbr_pkg::S_LOOK: begin
        state_d = stat_i.need_scan ? pbr_pkg::S_SCAN : pbr_pkg::S_RESP;
      end
      pbr_pkg::S_SCAN: begin
        if (stat_i.scan_done) state_d = pbr_pkg::S_EVICT;
      end
      pbr_pkg::S_EVICT: begin
        state_d = (stat_i.victim_ok && stat_i.is_get) ? pbr_pkg::S_INSTALL
                                                      : pbr_pkg::S_RESP;
      end
      pbr_pkg::S_INSTALL: state_d = pbr_pkg::S_RESP;
      pbr_pkg::S_RESP:    state_d = pbr_pkg::S_IDLE;
      default:            state_d = pbr_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    case (state_q)
      pbr_pkg::S_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      pbr_pkg::S_LOOK: begin
        cmd_o.exec      = !stat_i.need_scan;
        cmd_o.scan_init = stat_i.need_scan;
      end
      pbr_pkg::S_SCAN: begin
        cmd_o.scan_step = !stat_i.scan_done;
      end
      pbr_pkg::S_EVICT:   cmd_o.evict = 1'b1;
      pbr_pkg::S_INSTALL: cmd_o.exec = 1'b1;
      pbr_pkg::S_RESP:    done_o = 1'b1;
      default:            busy_o = 1'b1;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/pbr_dp.sv -----
// ----------------------------------------------------------------------------
// Page buffer replacement datapath
// Frame directory, replacement ring, victim scan and result registers.
// ----------------------------------------------------------------------------
module pbr_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pbr_pkg::cmd_t                    cmd_i,
  output pbr_pkg::stat_t                   stat_o,
  input  logic                             cfg_valid_i,
  input  logic [pbr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [pbr_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic [2:0]                       req_type_i,
  input  logic [pbr_pkg::IdW-1:0]          page_id_i,
  input  logic [pbr_pkg::IdW-1:0]          page_generation_i,
  output logic [2:0]                       status_o,
  output logic                             hit_o,
  output logic [pbr_pkg::FidxW-1:0]        frame_index_o,
  output logic [7:0]                       pin_count_o,
  output logic                             victim_valid_o,
  output logic [pbr_pkg::IdW-1:0]          victim_page_id_o,
  output logic [pbr_pkg::IdW-1:0]          victim_generation_o,
  output logic                             victim_dirty_o
);

  localparam int NF    = pbr_pkg::NumFrames;
  localparam int FW    = pbr_pkg::FidxW;
  localparam int CW    = pbr_pkg::CntW;
  localparam int PW    = pbr_pkg::PinW;
  localparam int SW    = pbr_pkg::StepW;
  localparam int IW    = pbr_pkg::IdW;
  localparam int TW    = pbr_pkg::TsW;
  localparam int CIW   = pbr_pkg::CfgIdxW;
  localparam logic [PW-1:0] PinMax = {PW{1'b1}};

  // Control state of the directory.
  logic [NF-1:0]         valid_q, valid_d, dirty_q, dirty_d, ref_q, ref_d;
  logic [PW-1:0]         pins_q [NF], pins_d [NF];
  logic [CW-1:0]         rcnt_q, rcnt_d;
  logic [FW-1:0]         hand_q, hand_d;
  logic [TW-1:0]         uctr_q, uctr_d;
  logic [1:0]            policy_q, policy_d;
  logic [CW-1:0]         cap_q, cap_d;

  // Payload state, only read for valid frames and live ring entries.
  logic [IW-1:0]         page_q [NF], page_d [NF];
  logic [IW-1:0]         gen_q [NF], gen_d [NF];
  logic [TW-1:0]         ldat_q [NF], ldat_d [NF];
  logic [TW-1:0]         usat_q [NF], usat_d [NF];
  logic [FW-1:0]         ring_q [NF], ring_d [NF];

  // Latched request and scan state.
  logic [2:0]            req_q, req_d;
  logic [IW-1:0]         id_q, id_d, rgen_q, rgen_d;
  logic [FW-1:0]         sidx_q, sidx_d, vict_q, vict_d;
  logic [SW-1:0]         steps_q, steps_d;
  logic                  sdone_q, sdone_d, vok_q, vok_d;
  logic [TW-1:0]         best_q, best_d;

  // Result registers.
  logic [2:0]            st_q, st_d;
  logic                  hit_q, hit_d, vv_q, vv_d, vd_q, vd_d;
  logic [FW-1:0]         fidx_q, fidx_d;
  logic [7:0]            pc_q, pc_d;
  logic [IW-1:0]         vid_q, vid_d, vgen_q, vgen_d;

  // Lookup helpers.
  logic                  found, has_free, any_pin;
  logic [FW-1:0]         fnd, free_idx;
  logic [CW-1:0]         used, cap_eff;
  logic                  rm_hit;
  logic [FW-1:0]         rm_tgt, rm_pos;

  always_comb begin
    found    = 1'b0;
    fnd      = '0;
    has_free = 1'b0;
    free_idx = '0;
    any_pin  = 1'b0;
    for (int i = NF - 1; i >= 0; i--) begin
      if (valid_q[i] && page_q[i] == id_q) begin
        found = 1'b1;
        fnd   = FW'(i);
      end
      if (!valid_q[i]) begin
        has_free = 1'b1;
        free_idx = FW'(i);
      end
      if (valid_q[i] && pins_q[i] != '0) any_pin = 1'b1;
    end
    used = CW'($countones(valid_q));
    if (cap_q == '0) cap_eff = CW'(1);
    else if (cap_q > CW'(NF)) cap_eff = CW'(NF);
    else cap_eff = cap_q;
  end

  // Position of the frame to take out of the ring.
  assign rm_tgt = cmd_i.evict ? vict_q : fnd;
  always_comb begin
    rm_hit = 1'b0;
    rm_pos = '0;
    for (int k = NF - 1; k >= 0; k--) begin
      if (CW'(k) < rcnt_q && ring_q[k] == rm_tgt) begin
        rm_hit = 1'b1;
        rm_pos = FW'(k);
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    stat_o.is_get    = (req_q == pbr_pkg::REQ_GET);
    stat_o.need_scan = ((req_q == pbr_pkg::REQ_GET && !found) ||
                        req_q == pbr_pkg::REQ_ROOM) && (used >= cap_eff);
    stat_o.scan_done = sdone_q;
    stat_o.victim_ok = vok_q;
  end

  // Clock scan candidate.
  logic [FW-1:0] ch_eff, ch_next, cf;
  logic [SW-1:0] limit;
  always_comb begin
    ch_eff  = ({1'b0, hand_q} >= rcnt_q) ? '0 : hand_q;
    cf      = ring_q[ch_eff];
    ch_next = ({1'b0, ch_eff} + CW'(1) == rcnt_q) ? '0 : ch_eff + FW'(1);
    limit   = {rcnt_q, 1'b0};
  end

  // Next state of the whole directory.
  always_comb begin
    logic [TW-1:0] age;
    logic [TW-1:0] nts;
    logic          do_rm;
    logic [FW-1:0] hh;
    valid_d  = valid_q;  dirty_d = dirty_q;  ref_d = ref_q;
    pins_d   = pins_q;   page_d  = page_q;   gen_d = gen_q;
    ldat_d   = ldat_q;   usat_d  = usat_q;   ring_d = ring_q;
    rcnt_d   = rcnt_q;   hand_d  = hand_q;   uctr_d = uctr_q;
    policy_d = policy_q; cap_d   = cap_q;
    req_d    = req_q;    id_d    = id_q;     rgen_d = rgen_q;
    sidx_d   = sidx_q;   vict_d  = vict_q;   steps_d = steps_q;
    sdone_d  = sdone_q;  vok_d   = vok_q;    best_d = best_q;
    st_d     = st_q;     hit_d   = hit_q;    fidx_d = fidx_q;  pc_d = pc_q;
    vv_d     = vv_q;     vid_d   = vid_q;    vgen_d = vgen_q;  vd_d = vd_q;
    do_rm    = 1'b0;
    age      = '0;
    hh       = '0;
    nts      = uctr_q + TW'(1);

    // Configuration writes.
    if (cfg_valid_i) begin
      if (cfg_index_i == CIW'(pbr_pkg::CFG_POLICY)) begin
        if (cfg_data_i[1:0] != pbr_pkg::POL_BAD) begin
          policy_d = cfg_data_i[1:0];
          hand_d   = '0;
        end
      end else if (cfg_index_i == CIW'(pbr_pkg::CFG_CAPACITY)) begin
        cap_d = cfg_data_i;
      end
    end

    // Latch a new request and clear the result.
    if (cmd_i.load) begin
      req_d  = req_type_i;
      id_d   = page_id_i;
      rgen_d = page_generation_i;
      st_d   = pbr_pkg::ST_OK;
      hit_d  = 1'b0;
      fidx_d = '0;
      pc_d   = '0;
      vv_d   = 1'b0;
      vid_d  = '0;
      vgen_d = '0;
      vd_d   = 1'b0;
    end

    // Execute a request that needs no victim.
    if (cmd_i.exec) begin
      case (req_q)
        pbr_pkg::REQ_GET: begin
          if (found) begin
            hit_d  = 1'b1;
            fidx_d = fnd;
            if (gen_q[fnd] != rgen_q) begin
              st_d = pbr_pkg::ST_STALE;
              pc_d = pins_q[fnd][7:0];
            end else begin
              uctr_d      = nts;
              usat_d[fnd] = nts;
              ref_d[fnd]  = 1'b1;
              if (pins_q[fnd] < PinMax) pins_d[fnd] = pins_q[fnd] + PW'(1);
              pc_d = pins_d[fnd][7:0];
            end
          end else if (has_free) begin
            valid_d[free_idx] = 1'b1;
            page_d[free_idx]  = id_q;
            gen_d[free_idx]   = rgen_q;
            pins_d[free_idx]  = PW'(1);
            dirty_d[free_idx] = 1'b0;
            ref_d[free_idx]   = 1'b1;
            uctr_d            = nts;
            ldat_d[free_idx]  = nts;
            usat_d[free_idx]  = nts;
            if (rcnt_q < CW'(NF)) begin
              ring_d[rcnt_q[FW-1:0]] = free_idx;
              rcnt_d = rcnt_q + CW'(1);
            end
            fidx_d = free_idx;
            pc_d   = 8'd1;
          end else begin
            st_d = pbr_pkg::ST_ALL_PIN;
          end
        end
        pbr_pkg::REQ_UNPIN, pbr_pkg::REQ_DIRTY,
        pbr_pkg::REQ_FLUSH, pbr_pkg::REQ_FREE: begin
          if (!found) begin
            st_d = pbr_pkg::ST_ABSENT;
          end else begin
            hit_d  = 1'b1;
            fidx_d = fnd;
            pc_d   = pins_q[fnd][7:0];
            if (gen_q[fnd] != rgen_q) begin
              st_d = pbr_pkg::ST_STALE;
            end else if (req_q == pbr_pkg::REQ_UNPIN) begin
              if (pins_q[fnd] != '0) pins_d[fnd] = pins_q[fnd] - PW'(1);
              pc_d = pins_d[fnd][7:0];
            end else if (req_q == pbr_pkg::REQ_DIRTY) begin
              dirty_d[fnd] = 1'b1;
            end else if (pins_q[fnd] != '0) begin
              st_d = pbr_pkg::ST_PINNED;
            end else if (req_q == pbr_pkg::REQ_FLUSH) begin
              vv_d         = 1'b1;
              vid_d        = page_q[fnd];
              vgen_d       = gen_q[fnd];
              vd_d         = dirty_q[fnd];
              dirty_d[fnd] = 1'b0;
            end else begin
              do_rm        = 1'b1;
              valid_d[fnd] = 1'b0;
              dirty_d[fnd] = 1'b0;
              ref_d[fnd]   = 1'b0;
              pc_d         = '0;
            end
          end
        end
        pbr_pkg::REQ_CLEAR: begin
          if (any_pin) begin
            st_d = pbr_pkg::ST_PINNED;
          end else begin
            valid_d = '0;
            dirty_d = '0;
            ref_d   = '0;
            for (int i = 0; i < NF; i++) pins_d[i] = '0;
            rcnt_d  = '0;
            hand_d  = '0;
          end
        end
        default: st_d = pbr_pkg::ST_OK;
      endcase
    end

    // Start a victim scan.
    if (cmd_i.scan_init) begin
      sidx_d  = '0;
      steps_d = '0;
      sdone_d = 1'b0;
      vok_d   = 1'b0;
      vict_d  = '0;
      best_d  = '0;
    end

    // One scan step: one frame for LRU and FIFO, one ring slot for CLOCK.
    if (cmd_i.scan_step) begin
      if (policy_q == pbr_pkg::POL_CLOCK) begin
        if (steps_q >= limit) begin
          sdone_d = 1'b1;
        end else if (pins_q[cf] == '0 && !ref_q[cf]) begin
          vok_d   = 1'b1;
          vict_d  = cf;
          hand_d  = ch_eff;
          sdone_d = 1'b1;
        end else begin
          if (pins_q[cf] == '0) ref_d[cf] = 1'b0;
          hand_d  = ch_next;
          steps_d = steps_q + SW'(1);
        end
      end else begin
        age = (policy_q == pbr_pkg::POL_LRU) ? usat_q[sidx_q] : ldat_q[sidx_q];
        if (valid_q[sidx_q] && pins_q[sidx_q] == '0 && (!vok_q || age < best_q)) begin
          vok_d  = 1'b1;
          vict_d = sidx_q;
          best_d = age;
        end
        sidx_d = sidx_q + FW'(1);
        if (sidx_q == FW'(NF - 1)) sdone_d = 1'b1;
      end
    end

    // Evict the chosen victim.
    if (cmd_i.evict) begin
      if (vok_q) begin
        vv_d            = 1'b1;
        vid_d           = page_q[vict_q];
        vgen_d          = gen_q[vict_q];
        vd_d            = dirty_q[vict_q];
        do_rm           = 1'b1;
        valid_d[vict_q] = 1'b0;
        pins_d[vict_q]  = '0;
        dirty_d[vict_q] = 1'b0;
        ref_d[vict_q]   = 1'b0;
        if (req_q == pbr_pkg::REQ_ROOM) fidx_d = vict_q;
      end else begin
        st_d = pbr_pkg::ST_ALL_PIN;
      end
    end

    // Take the frame out of the ring and keep the hand on its entry.
    if (do_rm && rm_hit) begin
      for (int k = 0; k < NF - 1; k++) begin
        if (FW'(k) >= rm_pos) ring_d[k] = ring_q[k + 1];
      end
      rcnt_d = rcnt_q - CW'(1);
      hh     = hand_q;
      if (rm_pos < hh) hh = hh - FW'(1);
      if ({1'b0, hh} >= rcnt_q - CW'(1)) hh = '0;
      hand_d = hh;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      dirty_q  <= '0;
      ref_q    <= '0;
      for (int i = 0; i < NF; i++) pins_q[i] <= '0;
      rcnt_q   <= '0;
      hand_q   <= '0;
      uctr_q   <= '0;
      policy_q <= pbr_pkg::POL_LRU;
      cap_q    <= CW'(NF);
      sdone_q  <= 1'b0;
      vok_q    <= 1'b0;
      steps_q  <= '0;
      sidx_q   <= '0;
    end else begin
      valid_q  <= valid_d;
      dirty_q  <= dirty_d;
      ref_q    <= ref_d;
      pins_q   <= pins_d;
      rcnt_q   <= rcnt_d;
      hand_q   <= hand_d;
      uctr_q   <= uctr_d;
      policy_q <= policy_d;
      cap_q    <= cap_d;
      sdone_q  <= sdone_d;
      vok_q    <= vok_d;
      steps_q  <= steps_d;
      sidx_q   <= sidx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    page_q <= page_d;
    gen_q  <= gen_d;
    ldat_q <= ldat_d;
    usat_q <= usat_d;
    ring_q <= ring_d;
    req_q  <= req_d;
    id_q   <= id_d;
    rgen_q <= rgen_d;
    vict_q <= vict_d;
    best_q <= best_d;
    st_q   <= st_d;
    hit_q  <= hit_d;
    fidx_q <= fidx_d;
    pc_q   <= pc_d;
    vv_q   <= vv_d;
    vid_q  <= vid_d;
    vgen_q <= vgen_d;
    vd_q   <= vd_d;
  end

  assign status_o            = st_q;
  assign hit_o               = hit_q;
  assign frame_index_o       = fidx_q;
  assign pin_count_o         = pc_q;
  assign victim_valid_o      = vv_q;
  assign victim_page_id_o    = vid_q;
  assign victim_generation_o = vgen_q;
  assign victim_dirty_o      = vd_q;

endmodule

// ----- design/page_buffer_replacement.sv -----
// ----------------------------------------------------------------------------
// Page buffer replacement
// Buffer pool frame directory with LRU, FIFO or CLOCK victim selection.
//
//   Channel   Handshake                    Payload
//   request   start_i, taken when !busy_o  req_type_i, page_id_i,
//                                          page_generation_i
//   result    done_o, one cycle strobe     status_o ... victim_dirty_o
//   config    cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// A request without a victim search passes the lookup state and then the
// result state. A search adds a scan, one frame per cycle over all frames
// for LRU and FIFO or one ring slot per cycle over at most two passes of
// the ring for CLOCK, then the evict state and, for a get whose scan found
// a victim, the install state.
// Reset empties the directory at once; no clearing pass.
// The result strobe cannot be stalled; config writes are always ready.
// ----------------------------------------------------------------------------
module page_buffer_replacement (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [2:0]                   req_type_i,
  input  logic [pbr_pkg::IdW-1:0]      page_id_i,
  input  logic [pbr_pkg::IdW-1:0]      page_generation_i,
  output logic                         done_o,
  output logic [2:0]                   status_o,
  output logic                         hit_o,
  output logic [pbr_pkg::FidxW-1:0]    frame_index_o,
  output logic [7:0]                   pin_count_o,
  output logic                         victim_valid_o,
  output logic [pbr_pkg::IdW-1:0]      victim_page_id_o,
  output logic [pbr_pkg::IdW-1:0]      victim_generation_o,
  output logic                         victim_dirty_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pbr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pbr_pkg::CfgDataW-1:0] cfg_data_i
);

  pbr_pkg::cmd_t  cmd;
  pbr_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  // Sequencer.
  pbr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Directory and scan datapath.
  pbr_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .req_type_i          (req_type_i),
    .page_id_i           (page_id_i),
    .page_generation_i   (page_generation_i),
    .status_o            (status_o),
    .hit_o               (hit_o),
    .frame_index_o       (frame_index_o),
    .pin_count_o         (pin_count_o),
    .victim_valid_o      (victim_valid_o),
    .victim_page_id_o    (victim_page_id_o),
    .victim_generation_o (victim_generation_o),
    .victim_dirty_o      (victim_dirty_o)
  );

endmodule
